/* design/psynth_pkg.sv */
`timescale 1ns / 1ps

package psynth_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;

    localparam mode_t MODE_TICK   = 2'd0;
    localparam mode_t MODE_LOAD   = 2'd1;
    localparam mode_t MODE_APPEND = 2'd2;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_SHORT = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    localparam logic [11:0] RING_LENGTH_RESET = 12'd100;

    // floor(u / 250) equals (u * RECIP_MULT) >> RECIP_SHIFT for every u below 2^17.
    localparam logic [16:0] RECIP_MULT  = 17'd67109;
    localparam int          RECIP_SHIFT = 24;
    localparam logic [16:0] DIV_BIAS    = 17'd250;

    // Control bits that travel with an item from the issue stage to the write stage.
    typedef struct packed {
        logic    tick;       // accepted tick: front takes the next sample, damped value written
        logic    set_front;  // load value becomes the new front
        logic    we;         // ring write pending
        logic    nonempty;   // ring holds samples after this item
        status_t status;
    } s2_ctrl_t;

    // Damping filter: t = (a + b) / 2 truncated toward zero, then
    // ceil(0.996 * t), which equals t - floor(t / 250).
    function automatic sample_t damp(input sample_t a, input sample_t b);
        logic [16:0] sum;
        logic [16:0] rounded;
        logic [16:0] t;
        logic [16:0] mag;
        logic [33:0] prod;
        logic [9:0]  q;
        logic [16:0] fl;
        logic [16:0] v;
        sum     = {a[15], a} + {b[15], b};
        rounded = sum + {16'd0, sum[16]};
        t       = {rounded[16], rounded[16:1]};
        // For negative t, floor(t/250) = -floor((-t + 249) / 250).
        mag     = t[16] ? (~t + DIV_BIAS) : t;
        prod    = 34'(mag) * 34'(RECIP_MULT);
        q       = prod[RECIP_SHIFT +: 10];
        fl      = t[16] ? (17'd0 - 17'(q)) : 17'(q);
        v       = t - fl;
        return sample_t'(v[15:0]);
    endfunction

endpackage

/* design/plucked_string_synth_core.sv */
`timescale 1ns / 1ps

// Plucked string synthesizer core.
//
// The input channel (in_valid, in_stall) carries one transaction per item:
// mode selects a tick, a begin-load (empty the ring, store value) or an append.
// The output channel (out_valid, out_stall) returns exactly one transaction per
// input item, in order, holding the front sample, the running tick count and a
// status code (ok, tick rejected on a short ring, append dropped on a full ring).
//
// Items pass the write stage, then the output register. Throughput is one item
// per cycle unless the receiver stalls: the ring is a dual-port memory with one
// write and one registered read port; each item needs at most one read and one
// write. The ring capacity is ring_length clamped to 2..MAX_RING; the user must
// drive ring_length_we / ring_length_wdata while the core is idle (not enforced).
//
// After reset the ring is empty, the tick count is zero and ring_length is 100.
// No memory clearing pass is needed since only stored samples are ever read.
// When the receiver stalls, the result waits in the output register; one more
// item is still taken into the write stage, and further input is then stalled.
module plucked_string_synth_core #(
    parameter int MAX_RING = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ring_length_we,
    input  logic [11:0]           ring_length_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  psynth_pkg::mode_t     mode,
    input  psynth_pkg::sample_t   value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output psynth_pkg::sample_t   front_sample,
    output logic [31:0]           tick_count,
    output psynth_pkg::status_t   status
);

    import psynth_pkg::*;

    localparam int AW = (MAX_RING > 2) ? $clog2(MAX_RING) : 1;
    localparam int FW = $clog2(MAX_RING + 1);
    localparam int SW = FW + 1;
    localparam int CW = (FW > 12) ? FW : 12;

    // Adds an offset of at most MAX_RING to a ring position, wrapping once.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [FW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(MAX_RING))
        begin
            s = s - SW'(MAX_RING);
        end
        return AW'(s);
    endfunction

    // Configuration and issue-stage control state.
    logic [11:0]   ring_length_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [31:0]   ticks_reg;
    logic [31:0]   ticks_next;
    logic [FW-1:0] cap;
    logic [CW-1:0] cap_wide;

    // Write stage.
    logic          s2_valid_reg;
    s2_ctrl_t      s2_ctrl_reg;
    s2_ctrl_t      s2_ctrl_next;
    logic [AW-1:0] s2_waddr_reg;
    logic [AW-1:0] s2_waddr_next;
    sample_t       s2_value_reg;
    logic [31:0]   s2_ticks_reg;
    sample_t       front_reg;
    sample_t       front_next;

    // Ring memory and read-after-write bypass.
    sample_t       ring_mem [MAX_RING];
    sample_t       rd_data_reg;
    logic          byp_hit_reg;
    logic          byp_hit_next;
    sample_t       byp_data_reg;
    sample_t       next_sample;
    sample_t       wdata;

    // Output register.
    logic          out_valid_reg;
    sample_t       out_front_reg;
    logic [31:0]   out_ticks_reg;
    status_t       out_status_reg;

    logic          out_load;
    logic          s2_fire;
    logic          accept;

    assign out_load = !out_valid_reg || !out_stall;
    assign s2_fire  = s2_valid_reg && out_load;
    assign in_stall = s2_valid_reg && !out_load;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cap_wide = CW'(ring_length_reg);
        if (cap_wide < CW'(2))
        begin
            cap_wide = CW'(2);
        end
        else if (cap_wide > CW'(MAX_RING))
        begin
            cap_wide = CW'(MAX_RING);
        end
        cap = FW'(cap_wide);
    end

    // Issue stage: all pointer and count bookkeeping is independent of sample
    // data, so it completes here and only the memory access is deferred.
    always_comb
    begin
        head_next     = head_reg;
        fill_next     = fill_reg;
        ticks_next    = ticks_reg;
        s2_waddr_next = head_reg;
        s2_ctrl_next  = '0;
        unique case (mode)
            MODE_TICK:
            begin
                if (fill_reg < FW'(2))
                begin
                    s2_ctrl_next.status = STATUS_SHORT;
                end
                else
                begin
                    head_next          = wrap_add(head_reg, FW'(1));
                    s2_waddr_next      = wrap_add(head_reg, fill_reg);
                    ticks_next         = ticks_reg + 32'd1;
                    s2_ctrl_next.tick  = 1'b1;
                    s2_ctrl_next.we    = 1'b1;
                end
            end
            MODE_LOAD:
            begin
                fill_next              = FW'(1);
                s2_ctrl_next.we        = 1'b1;
                s2_ctrl_next.set_front = 1'b1;
            end
            MODE_APPEND:
            begin
                if (fill_reg >= cap)
                begin
                    s2_ctrl_next.status = STATUS_FULL;
                end
                else
                begin
                    s2_waddr_next          = wrap_add(head_reg, fill_reg);
                    fill_next              = fill_reg + FW'(1);
                    s2_ctrl_next.we        = 1'b1;
                    s2_ctrl_next.set_front = (fill_reg == '0);
                end
            end
            default:
            begin
                s2_ctrl_next.status = STATUS_OK;
            end
        endcase
        s2_ctrl_next.nonempty = (fill_next != '0);
    end

    // A tick's next sample may be the one the write stage stores this very cycle.
    assign byp_hit_next = s2_fire && s2_ctrl_reg.we && (s2_waddr_reg == head_next);

    // Write stage: for a tick the next sample comes from memory (or the bypass)
    // and the damped result (else the load/append value) is written to the ring tail.
    assign next_sample = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign wdata       = s2_ctrl_reg.tick ? damp(front_reg, next_sample) : s2_value_reg;

    always_comb
    begin
        front_next = front_reg;
        if (s2_ctrl_reg.tick)
        begin
            front_next = next_sample;
        end
        else if (s2_ctrl_reg.set_front)
        begin
            front_next = s2_value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && s2_ctrl_reg.we)
        begin
            ring_mem[s2_waddr_reg] <= wdata;
        end
        if (accept)
        begin
            rd_data_reg <= ring_mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg <= RING_LENGTH_RESET;
            head_reg        <= '0;
            fill_reg        <= '0;
            ticks_reg       <= '0;
            s2_valid_reg    <= 1'b0;
            byp_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ring_length_we)
            begin
                ring_length_reg <= ring_length_wdata;
            end
            if (accept)
            begin
                head_reg     <= head_next;
                fill_reg     <= fill_next;
                ticks_reg    <= ticks_next;
                byp_hit_reg  <= byp_hit_next;
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_ctrl_reg  <= s2_ctrl_next;
            s2_waddr_reg <= s2_waddr_next;
            s2_value_reg <= value;
            s2_ticks_reg <= ticks_next;
            byp_data_reg <= wdata;
        end
        if (s2_fire)
        begin
            front_reg      <= front_next;
            out_front_reg  <= s2_ctrl_reg.nonempty ? front_next : sample_t'(0);
            out_ticks_reg  <= s2_ticks_reg;
            out_status_reg <= s2_ctrl_reg.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign front_sample = out_front_reg;
    assign tick_count   = out_ticks_reg;
    assign status       = out_status_reg;

endmodule

/* test/tb_plucked_string_synth_core.sv */
`timescale 1ns / 1ps

// Testbench for the plucked string synthesizer core.
module tb_plucked_string_synth_core;

    import psynth_pkg::*;

    localparam int MAX_RING = 2048;

    // The fourth mode code has no meaning; the core must ignore it and report ok.
    localparam mode_t MODE_UNUSED = 2'd3;

    // Far above the slowest legal run: about twelve hundred items, each waiting
    // out random gaps on the sender side and random stalls on the receiver side.
    localparam int CYCLE_LIMIT = 400000;

    // One expected output transaction of the core.
    typedef struct packed {
        sample_t     front;
        logic [31:0] ticks;
        status_t     status;
    } string_result_t;

    // The scoreboard keeps its own copy of the delay ring and the tick counter.
    // Every accepted input transaction is run through this copy at once, and the
    // result it gives is queued until the core delivers its output transaction.
    class string_scoreboard;
        sample_t        ring[MAX_RING];
        logic [10:0]    head;
        logic [11:0]    fill;
        logic [31:0]    ticks;
        logic [11:0]    ring_length;
        string_result_t predicted_results[$];
        int             errors;

        function new();
            head        = '0;
            fill        = '0;
            ticks       = '0;
            ring_length = RING_LENGTH_RESET;
            errors      = 0;
        endfunction

        function int capacity();
            if (ring_length < 2)
                return 2;
            if (ring_length > MAX_RING)
                return MAX_RING;
            return ring_length;
        endfunction

        // Average of the two samples truncated toward zero, then scaled by
        // 0.996 and rounded up.
        function sample_t damped(sample_t a, sample_t b);
            int t;
            int n;
            t = (int'(a) + int'(b)) / 2;
            n = 996 * t;
            if (n >= 0)
                return sample_t'((n + 999) / 1000);
            return sample_t'(-((-n) / 1000));
        endfunction

        function void predict_item(mode_t m, sample_t v);
            sample_t        a;
            sample_t        b;
            logic [10:0]    slot;
            string_result_t r;
            r.status = STATUS_OK;
            case (m)
                MODE_TICK:
                begin
                    if (fill < 2)
                        r.status = STATUS_SHORT;
                    else
                    begin
                        a    = ring[head];
                        head = head + 11'd1;
                        b    = ring[head];
                        // Ring positions wrap at the memory size, not at the capacity.
                        slot       = head + fill[10:0] - 11'd1;
                        ring[slot] = damped(a, b);
                        ticks      = ticks + 32'd1;
                    end
                end
                MODE_LOAD:
                begin
                    fill       = 12'd1;
                    ring[head] = v;
                end
                MODE_APPEND:
                begin
                    if (fill >= capacity())
                        r.status = STATUS_FULL;
                    else
                    begin
                        slot       = head + fill[10:0];
                        ring[slot] = v;
                        fill       = fill + 12'd1;
                    end
                end
                default:
                    ;
            endcase
            r.front = (fill != 0) ? ring[head] : '0;
            r.ticks = ticks;
            predicted_results.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        endtask

        task check_output(sample_t f, logic [31:0] t, status_t s);
            string_result_t e;
            if (predicted_results.size() == 0)
            begin
                report("output with nothing predicted, front_sample", f, 0);
                return;
            end
            e = predicted_results.pop_front();
            if (f !== e.front)
                report("front_sample", f, e.front);
            if (t !== e.ticks)
                report("tick_count", t, e.ticks);
            if (s !== e.status)
                report("status", s, e.status);
        endtask
    endclass

    logic        clk               = 1'b0;
    logic        rst_n             = 1'b0;
    logic        ring_length_we    = 1'b0;
    logic [11:0] ring_length_wdata = '0;
    logic        in_valid          = 1'b0;
    logic        in_stall;
    mode_t       mode              = MODE_TICK;
    sample_t     value             = '0;
    logic        out_valid;
    logic        out_stall         = 1'b0;
    sample_t     front_sample;
    logic [31:0] tick_count;
    status_t     status;

    string_scoreboard sb;

    // Idle rates in percent; each phase of the run sets them.
    int send_idle_pct = 21;
    int recv_idle_pct = 70;
    int items_sent    = 0;
    int cycle_count   = 0;

    plucked_string_synth_core #(
        .MAX_RING(MAX_RING)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .ring_length_we   (ring_length_we),
        .ring_length_wdata(ring_length_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .value            (value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .front_sample     (front_sample),
        .tick_count       (tick_count),
        .status           (status)
    );

    always #6 clk = ~clk;

    // The receiver stalls at random. A fresh decision is made at every edge, so
    // stalls land on every stage of the core's pipeline.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Both channels are sampled at the rising edge, before any of this edge's
    // nonblocking updates take effect, which is how the core sees them too.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.predict_item(mode, value);
            if (out_valid && !out_stall)
                sb.check_output(front_sample, tick_count, status);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("plucked_string_synth_core test failed");
            $finish;
        end
    end

    // Extremes of the sample range, zero and -1 come up often; other values are uniform.
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Offers one transaction and holds it until the core takes it. Valid is
    // left high on return, so a call that follows in the same time step keeps
    // the channel busy without a gap; a random gap lowers it first.
    task automatic send_item(mode_t m, sample_t v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        if (m != MODE_UNUSED)
            items_sent++;
    endtask

    // Stops sending and waits until every predicted output has arrived. At least
    // one edge passes, so valid is never lowered and raised in the same step.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.predicted_results.size() != 0);
    endtask

    // The register is only written while the core is empty. Each input yields
    // an output, so once the queue is empty the core holds no item.
    task automatic set_ring_length(logic [11:0] rl);
        wait_for_results();
        repeat (2) @(posedge clk);
        ring_length_we    <= 1'b1;
        ring_length_wdata <= rl;
        @(posedge clk);
        ring_length_we <= 1'b0;
        sb.ring_length = rl;
    endtask

    // One pluck: a begin-load, appends that usually fill the ring exactly,
    // sometimes stop short and sometimes overrun it, then a run of ticks with
    // an occasional append mixed in.
    task automatic pluck();
        int cap;
        int n_app;
        int n_tick;
        cap = sb.capacity();
        case ($urandom_range(0, 3))
            0: n_app = $urandom_range(0, cap - 1);
            3: n_app = cap - 1 + $urandom_range(1, 3);
            default: n_app = cap - 1;
        endcase
        n_tick = $urandom_range(1, cap + 8);
        send_item(MODE_LOAD, rand_sample());
        repeat (n_app) send_item(MODE_APPEND, rand_sample());
        repeat (n_tick)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(MODE_APPEND, rand_sample());
            send_item(MODE_TICK, rand_sample());
        end
    endtask

    // Random traffic for one phase: mostly plucks, some loose transactions of
    // any mode, and now and then a pause until the core has drained.
    task automatic run_phase(int budget);
        int target;
        int r;
        target = items_sent + budget;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                wait_for_results();
            else if (r < 80)
                pluck();
            else
                send_item(mode_t'($urandom_range(0, 3)), rand_sample());
        end
    endtask

    initial
    begin
        int rl_list[10];
        int rl;
        rl_list = '{-1, 0, 3, 1, 7, 2, 16, 33, 5, -2};
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions at the reset capacity: ticks and appends on an
        // empty or one-sample ring, the unused mode, and damping of the extreme
        // sample pairs on both sides of zero.
        send_item(MODE_TICK, 16'sh1234);
        send_item(MODE_UNUSED, 16'sh5A5A);
        send_item(MODE_APPEND, 16'sh8000);
        send_item(MODE_TICK, 16'sh0000);
        send_item(MODE_LOAD, 16'sh7FFF);
        send_item(MODE_APPEND, 16'sh8000);
        send_item(MODE_TICK, 16'sh0000);
        send_item(MODE_TICK, 16'shFFFF);
        send_item(MODE_LOAD, 16'sh7FFF);
        send_item(MODE_APPEND, 16'sh7FFF);
        send_item(MODE_TICK, 16'sh7FFF);
        send_item(MODE_LOAD, 16'sh8000);
        send_item(MODE_APPEND, 16'sh8000);
        send_item(MODE_TICK, 16'sh8000);
        send_item(MODE_LOAD, 16'shFFFF);
        send_item(MODE_APPEND, 16'shFFFE);
        send_item(MODE_TICK, 16'sh0000);
        send_item(MODE_LOAD, 16'sh0001);
        send_item(MODE_APPEND, 16'sh0002);
        send_item(MODE_TICK, 16'sh0000);
        send_item(MODE_LOAD, 16'sh0003);
        send_item(MODE_APPEND, 16'shFFFC);
        send_item(MODE_TICK, 16'sh0000);
        send_item(MODE_UNUSED, 16'shFFFF);

        for (int i = 0; i < 10; i++)
        begin
            if (i == 3)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 21;
            end
            else if (i == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i == 1)
            begin
                // Shrink the capacity below the current fill: the stored samples
                // stay, appends are dropped, and ticks go on as before.
                send_item(MODE_LOAD, rand_sample());
                repeat (9) send_item(MODE_APPEND, rand_sample());
                set_ring_length(12'd5);
                send_item(MODE_APPEND, rand_sample());
                send_item(MODE_TICK, rand_sample());
                send_item(MODE_TICK, rand_sample());
                send_item(MODE_APPEND, rand_sample());
            end
            // The first phase keeps the reset capacity; the last one picks one.
            rl = rl_list[i];
            if (rl == -2)
                rl = $urandom_range(2, 40);
            if (rl >= 0)
                set_ring_length(12'(rl));
            run_phase(80);
        end

        // A short pass with a register value above the memory size, which
        // clamps to it: appends past the reset capacity are all kept, and the
        // ticks that follow damp a long string.
        set_ring_length(12'hFFF);
        send_item(MODE_LOAD, rand_sample());
        repeat (110) send_item(MODE_APPEND, rand_sample());
        repeat (20)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(MODE_APPEND, rand_sample());
            send_item(MODE_TICK, rand_sample());
        end
        set_ring_length(12'd2048);
        repeat (5) send_item(MODE_TICK, rand_sample());
        send_item(MODE_APPEND, rand_sample());

        wait_for_results();
        repeat (10) @(posedge clk);
        if (sb.predicted_results.size() != 0)
            sb.report("outputs never delivered", sb.predicted_results.size(), 0);
        if (sb.errors == 0)
            $display("plucked_string_synth_core test passed");
        else
            $display("plucked_string_synth_core test failed");
        $finish;
    end

endmodule

/* plucked_string_synth_core.f */
design/psynth_pkg.sv
design/plucked_string_synth_core.sv
test/tb_plucked_string_synth_core.sv
